### design/uvdh_pkg.sv
// Shared types and constants for the U/V disparity histogram block.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package uvdh_pkg;

  // Request kinds carried on the input stream's tuser
  typedef enum logic [1:0] {
    ReqAdd   = 2'd0,
    ReqReadU = 2'd1,
    ReqReadV = 2'd2,
    ReqClear = 2'd3
  } req_e;

  // Field widths fixed by the stream format
  localparam int unsigned ROW_W   = 10;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned DISP_W  = 8;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned SPAN_W  = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

### design/uvdh_bank.sv
// One histogram store: synchronous RAM with a registered read port and
// write-to-read forwarding. Depends on uvdh_pkg for the count width.
`default_nettype none

module uvdh_bank import uvdh_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  input  wire logic                       wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  wire logic [COUNT_W-1:0]         wr_data_i,
  output logic      [COUNT_W-1:0]         rd_data_o
);

  logic [COUNT_W-1:0] mem_q [DEPTH];
  logic [COUNT_W-1:0] mem_rdata_q;
  logic [COUNT_W-1:0] fwd_data_q;
  logic               fwd_hit_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      mem_rdata_q <= mem_q[rd_addr_i];
      fwd_data_q  <= wr_data_i;
    end
  end

  // Capture a write landing on the entry read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_data_q : mem_rdata_q;

endmodule

`default_nettype wire

### design/uv_disparity_histogram.sv
// U/V disparity histogram: request stream in, one result per request out.
// A request passes the read stage and the update stage; its result is then held in the
// output register. Throughput: one request per cycle, set by the read-modify-write of
// both stores, while the output takes results and no clear is in the update stage.
// Reset and every clear request start a clearing pass over both stores, during which
// no request is taken. Depends on uvdh_pkg and uvdh_bank.
`default_nettype none

module uv_disparity_histogram import uvdh_pkg::*; #(
  parameter int unsigned MAX_COLS  = 1024,
  parameter int unsigned MAX_ROWS  = 1024,
  parameter int unsigned DISP_BINS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: pixel_row[9:0], pixel_col[19:10], disparity[27:20], zero pad[31:28]
  input  wire logic [31:0] s_axis_tdata,
  // tuser: req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: cell_count[7:0], disparity_span[16:8], zero pad[23:17]
  output logic      [23:0] m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);

  localparam int unsigned DEPTH_U   = DISP_BINS * MAX_COLS;
  localparam int unsigned DEPTH_V   = MAX_ROWS * DISP_BINS;
  localparam int unsigned AW_U      = $clog2(DEPTH_U);
  localparam int unsigned AW_V      = $clog2(DEPTH_V);
  localparam int unsigned DEPTH_MAX = (DEPTH_U > DEPTH_V) ? DEPTH_U : DEPTH_V;
  localparam int unsigned CW        = $clog2(DEPTH_MAX);

  // Unpack the input transfer
  req_e              in_req;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [DISP_W-1:0] in_disp;
  logic              in_accept;
  logic              row_ok, col_ok, disp_ok, in_ok;
  logic [AW_U-1:0]   in_u_addr;
  logic [AW_V-1:0]   in_v_addr;

  assign in_req    = req_e'(s_axis_tuser);
  assign in_row    = s_axis_tdata[9:0];
  assign in_col    = s_axis_tdata[19:10];
  assign in_disp   = s_axis_tdata[27:20];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Range checks and store addresses for the read stage
  always_comb begin
    row_ok    = 32'(in_row) < MAX_ROWS;
    col_ok    = 32'(in_col) < MAX_COLS;
    disp_ok   = 32'(in_disp) < DISP_BINS;
    in_u_addr = AW_U'(32'(in_disp) * MAX_COLS + 32'(in_col));
    in_v_addr = AW_V'(32'(in_row) * DISP_BINS + 32'(in_disp));
    case (in_req)
      ReqAdd:   in_ok = row_ok && col_ok && disp_ok;
      ReqReadU: in_ok = col_ok && disp_ok;
      ReqReadV: in_ok = row_ok && disp_ok;
      default:  in_ok = 1'b0;
    endcase
  end

  // Update stage registers
  logic              b_valid_q, b_valid_d;
  req_e              b_req_q;
  logic              b_ok_q;
  logic [DISP_W-1:0] b_disp_q;
  logic [AW_U-1:0]   b_u_addr_q;
  logic [AW_V-1:0]   b_v_addr_q;

  // Clearing pass and tracked maximum
  logic              clr_active_q, clr_active_d;
  logic [CW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [DISP_W-1:0] max_q, max_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_count_q;
  logic [SPAN_W-1:0]  out_span_q;

  logic               out_free;
  logic               b_done;
  logic               b_add;
  logic [COUNT_W-1:0] u_rdata, v_rdata;
  logic [COUNT_W-1:0] u_inc, v_inc;
  logic [COUNT_W-1:0] res_count;

  assign out_free = !out_valid_q || m_axis_tready;
  assign b_done   = b_valid_q && out_free;
  assign b_add    = b_done && (b_req_q == ReqAdd) && b_ok_q;

  // Take a request unless clearing, or the update stage is blocked or holds a clear
  assign s_axis_tready = !clr_active_q &&
                         (!b_valid_q || (b_done && (b_req_q != ReqClear)));

  // Saturating increments of the addressed cells
  assign u_inc = (u_rdata == COUNT_MAX) ? u_rdata : u_rdata + COUNT_W'(1);
  assign v_inc = (v_rdata == COUNT_MAX) ? v_rdata : v_rdata + COUNT_W'(1);

  // Result of the request in the update stage
  always_comb begin
    res_count = '0;
    max_d     = max_q;
    if (b_done) begin
      case (b_req_q)
        ReqAdd: begin
          if (b_ok_q && (b_disp_q > max_q)) begin
            max_d = b_disp_q;
          end
        end
        ReqReadU: res_count = b_ok_q ? u_rdata : '0;
        ReqReadV: res_count = b_ok_q ? v_rdata : '0;
        default:  max_d = '0;
      endcase
    end
  end

  // Store write ports: clearing sweep or increment write-back
  logic               u_wr_en, v_wr_en;
  logic [AW_U-1:0]    u_wr_addr;
  logic [AW_V-1:0]    v_wr_addr;
  logic [COUNT_W-1:0] u_wr_data, v_wr_data;

  always_comb begin
    if (clr_active_q) begin
      u_wr_en   = {1'b0, clr_cnt_q} < (CW+1)'(DEPTH_U);
      v_wr_en   = {1'b0, clr_cnt_q} < (CW+1)'(DEPTH_V);
      u_wr_addr = clr_cnt_q[AW_U-1:0];
      v_wr_addr = clr_cnt_q[AW_V-1:0];
      u_wr_data = '0;
      v_wr_data = '0;
    end else begin
      u_wr_en   = b_add;
      v_wr_en   = b_add;
      u_wr_addr = b_u_addr_q;
      v_wr_addr = b_v_addr_q;
      u_wr_data = u_inc;
      v_wr_data = v_inc;
    end
  end

  uvdh_bank #(.DEPTH(DEPTH_U)) u_bank_u (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (in_u_addr),
    .wr_en_i   (u_wr_en),
    .wr_addr_i (u_wr_addr),
    .wr_data_i (u_wr_data),
    .rd_data_o (u_rdata)
  );

  uvdh_bank #(.DEPTH(DEPTH_V)) u_bank_v (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (in_v_addr),
    .wr_en_i   (v_wr_en),
    .wr_addr_i (v_wr_addr),
    .wr_data_i (v_wr_data),
    .rd_data_o (v_rdata)
  );

  // Next-state for control registers
  always_comb begin
    b_valid_d    = in_accept ? 1'b1 : (b_done ? 1'b0 : b_valid_q);
    out_valid_d  = b_done ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      if (clr_cnt_q == CW'(DEPTH_MAX - 1)) begin
        clr_active_d = 1'b0;
        clr_cnt_d    = '0;
      end else begin
        clr_cnt_d = clr_cnt_q + CW'(1);
      end
    end else if (b_done && (b_req_q == ReqClear)) begin
      clr_active_d = 1'b1;
      clr_cnt_d    = '0;
    end
  end

  // Hold control state; reset starts a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      max_q        <= '0;
    end else begin
      b_valid_q    <= b_valid_d;
      out_valid_q  <= out_valid_d;
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      max_q        <= max_d;
    end
  end

  // Advance request payload into the update stage, load the result
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      b_req_q    <= in_req;
      b_ok_q     <= in_ok;
      b_disp_q   <= in_disp;
      b_u_addr_q <= in_u_addr;
      b_v_addr_q <= in_v_addr;
    end
    if (b_done) begin
      out_count_q <= res_count;
      out_span_q  <= {1'b0, max_d} + SPAN_W'(1);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_span_q, out_count_q};

  // A clear leaving the update stage starts the sweep
  a_clear_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_done && (b_req_q == ReqClear)) |=> clr_active_q)
    else $error("clear request did not start the clearing pass");

  // Outside the sweep only an in-range add writes the stores
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((u_wr_en || v_wr_en) && !clr_active_q) |-> (b_valid_q && (b_req_q == ReqAdd) && b_ok_q))
    else $error("store write without an add in the update stage");

  // A new request never overwrites a stalled update stage
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (!b_valid_q || b_done))
    else $error("request accepted over a blocked update stage");

  // A result right after a clear reports empty maps
  a_clear_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_done && (b_req_q == ReqClear)) |=> (out_span_q == SPAN_W'(1) && out_count_q == '0))
    else $error("clear result does not show empty maps");

endmodule

`default_nettype wire
